### design/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

   localparam int GLYPH_WIDTH_LOG2 = 3;
   localparam int GLYPH_HEIGHT_DEFAULT = 16;

   localparam logic [8:0]  MAX_COLUMNS_RESET = 9'd80;
   localparam logic [8:0]  MAX_ROWS_RESET    = 9'd30;
   localparam logic [15:0] LINE_STRIDE_RESET = 16'd640;
   localparam logic [31:0] FRAME_BASE_RESET  = 32'd0;

   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_BS  = 8'd8;

   localparam logic [8:0] TAB_MASK = ~9'd7;

   typedef enum logic [1:0] {
      REG_MAX_COLUMNS = 2'd0,
      REG_MAX_ROWS    = 2'd1,
      REG_LINE_STRIDE = 2'd2,
      REG_FRAME_BASE  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_DRAW   = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SCROLL = 2'd2
   } command_type;

   typedef struct packed {
      logic        has_main;
      command_type main_cmd;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [7:0]  glyph;
      logic        has_scroll;
   } desc_type;

endpackage
`default_nettype wire

### design/tcc_decode.sv
`default_nettype none
module tcc_decode (
   input  wire logic [7:0]       char_code,
   input  wire logic [7:0]       cur_col,
   input  wire logic [7:0]       cur_row,
   input  wire logic [8:0]       max_columns,
   input  wire logic [8:0]       max_rows,
   output logic [7:0]            next_col,
   output logic [7:0]            next_row,
   output tcc_pkg::desc_type     desc
);
   import tcc_pkg::*;

   logic [8:0] cols;
   logic [8:0] rows;
   logic [8:0] row_inc;
   logic [8:0] tab_x;
   logic [8:0] adv_x;
   logic       wrap_row;

   always_comb begin
      cols = (max_columns == 9'd0) ? 9'd1 : ((max_columns > 9'd256) ? 9'd256 : max_columns);
      rows = (max_rows == 9'd0) ? 9'd1 : ((max_rows > 9'd256) ? 9'd256 : max_rows);
      row_inc  = {1'b0, cur_row} + 9'd1;
      wrap_row = row_inc >= rows;
      tab_x    = ({1'b0, cur_col} + 9'd8) & TAB_MASK;
      adv_x    = {1'b0, cur_col} + 9'd1;
   end

   always_comb begin
      next_col        = cur_col;
      next_row        = cur_row;
      desc.has_main   = 1'b0;
      desc.main_cmd   = CMD_DRAW;
      desc.col        = cur_col;
      desc.row        = cur_row;
      desc.glyph      = 8'd0;
      desc.has_scroll = 1'b0;
      case (char_code)
         CHAR_CR: begin
            next_col = 8'd0;
         end
         CHAR_LF: begin
            next_col = 8'd0;
            if (wrap_row) desc.has_scroll = 1'b1;
            else next_row = row_inc[7:0];
         end
         CHAR_TAB: begin
            if (tab_x >= cols) begin
               next_col = 8'd0;
               if (wrap_row) desc.has_scroll = 1'b1;
               else next_row = row_inc[7:0];
            end else begin
               next_col = tab_x[7:0];
            end
         end
         CHAR_BS: begin
            if (cur_col != 8'd0) begin
               next_col      = cur_col - 8'd1;
               desc.has_main = 1'b1;
               desc.main_cmd = CMD_CLEAR;
               desc.col      = cur_col - 8'd1;
            end
         end
         default: begin
            desc.has_main = 1'b1;
            desc.main_cmd = CMD_DRAW;
            desc.glyph    = char_code;
            if (adv_x >= cols) begin
               next_col = 8'd0;
               if (wrap_row) desc.has_scroll = 1'b1;
               else next_row = row_inc[7:0];
            end else begin
               next_col = adv_x[7:0];
            end
         end
      endcase
   end

endmodule
`default_nettype wire

### design/text_console_cursor_controller_top.sv
`default_nettype none
// Text console cursor controller. Each character byte moves the cursor and
// yields zero, one or two commands (draw or clear cell, then possibly a
// scroll), flagged by rsp_last on the final one. A character passes an input
// register, a decode stage that updates the cursor and forms row*line_stride,
// an address stage and the output register. One character can be taken
// every cycle while req_stall is low; the output register gives one command
// per cycle while rsp_stall is low, so a character that causes two commands
// occupies it for both. The user must write registers through the csr_
// port only while no character is in flight; the block does not enforce it.
module text_console_cursor_controller_top #(
   parameter int GLYPH_HEIGHT = tcc_pkg::GLYPH_HEIGHT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_command,
   output logic [7:0]       rsp_cell_column,
   output logic [7:0]       rsp_cell_row,
   output logic [31:0]      rsp_cell_address,
   output logic [7:0]       rsp_glyph_code,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import tcc_pkg::*;

   logic [8:0]  max_columns_ff;
   logic [8:0]  max_rows_ff;
   logic [15:0] line_stride_ff;
   logic [31:0] frame_base_ff;

   logic [7:0]  cursor_col_ff, cursor_row_ff;
   logic [7:0]  next_col, next_row;

   logic        s1_valid_ff;
   logic [7:0]  s1_char_ff;
   logic        s2_valid_ff;
   desc_type    s2_desc_ff;
   logic [23:0] s2_prod_ff;
   logic        s3_valid_ff;
   desc_type    s3_desc_ff;
   logic [31:0] s3_addr_ff;
   logic        s3_phase_ff;

   desc_type    dec_desc;
   logic        s3_done, s3_free, s2_free, s1_adv, req_take;
   logic        emit_entry;
   logic [31:0] addr_in;

   tcc_decode u_decode (
      .char_code   (s1_char_ff),
      .cur_col     (cursor_col_ff),
      .cur_row     (cursor_row_ff),
      .max_columns (max_columns_ff),
      .max_rows    (max_rows_ff),
      .next_col    (next_col),
      .next_row    (next_row),
      .desc        (dec_desc)
   );

   // phase 0 shows the cell command, phase 1 the scroll
   assign s3_done = s3_valid_ff && !rsp_stall &&
                    (s3_phase_ff || !s3_desc_ff.has_scroll);
   assign s3_free = !s3_valid_ff || s3_done;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_adv  = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;
   assign emit_entry = dec_desc.has_main || dec_desc.has_scroll;

   assign addr_in = frame_base_ff + 32'(s2_prod_ff) * 32'(GLYPH_HEIGHT)
                    + (32'(s2_desc_ff.col) << GLYPH_WIDTH_LOG2);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_columns_ff <= MAX_COLUMNS_RESET;
         max_rows_ff    <= MAX_ROWS_RESET;
         line_stride_ff <= LINE_STRIDE_RESET;
         frame_base_ff  <= FRAME_BASE_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_MAX_COLUMNS: max_columns_ff <= csr_wdata[8:0];
            REG_MAX_ROWS:    max_rows_ff    <= csr_wdata[8:0];
            REG_LINE_STRIDE: line_stride_ff <= csr_wdata[15:0];
            REG_FRAME_BASE:  frame_base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s3_phase_ff   <= 1'b0;
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
      end else begin
         if (req_take) s1_valid_ff <= 1'b1;
         else if (s1_adv) s1_valid_ff <= 1'b0;
         if (s1_adv) begin
            cursor_col_ff <= next_col;
            cursor_row_ff <= next_row;
         end
         // drop characters that cause no command
         if (s1_adv && emit_entry) s2_valid_ff <= 1'b1;
         else if (s3_free) s2_valid_ff <= 1'b0;
         if (s2_valid_ff && s3_free) begin
            s3_valid_ff <= 1'b1;
            s3_phase_ff <= !s2_desc_ff.has_main;
         end else if (s3_done) begin
            s3_valid_ff <= 1'b0;
         end else if (s3_valid_ff && !rsp_stall) begin
            s3_phase_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_char_ff <= req_char_code;
      if (s1_adv) begin
         s2_desc_ff <= dec_desc;
         s2_prod_ff <= {8'd0, line_stride_ff} * {16'd0, dec_desc.row};
      end
      if (s2_valid_ff && s3_free) begin
         s3_desc_ff <= s2_desc_ff;
         s3_addr_ff <= addr_in;
      end
   end

   always_comb begin
      rsp_valid = s3_valid_ff;
      if (s3_phase_ff) begin
         rsp_command      = CMD_SCROLL;
         rsp_cell_column  = 8'd0;
         rsp_cell_row     = 8'd0;
         rsp_cell_address = frame_base_ff;
         rsp_glyph_code   = 8'd0;
         rsp_last         = 1'b1;
      end else begin
         rsp_command      = s3_desc_ff.main_cmd;
         rsp_cell_column  = s3_desc_ff.col;
         rsp_cell_row     = s3_desc_ff.row;
         rsp_cell_address = s3_addr_ff;
         rsp_glyph_code   = s3_desc_ff.glyph;
         rsp_last         = !s3_desc_ff.has_scroll;
      end
   end

   a_scroll_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_SCROLL |-> rsp_last)
      else $error("scroll transaction not marked last");

   a_follow_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid && rsp_command == CMD_SCROLL)
      else $error("non-last transaction not followed by scroll");

   a_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with empty input register");

   a_entry_has_cmd: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_desc_ff.has_main || s2_desc_ff.has_scroll)
      else $error("pipeline entry without any command");

endmodule
`default_nettype wire
